FILE: sv/alarm_timer_controller_core_defines.svh
// ----------------------------------------------------------------------------
// alarm timer controller assertion macros
// implication checks on a clock with an active-low reset
// ----------------------------------------------------------------------------
`ifndef ALARM_TIMER_CONTROLLER_CORE_DEFINES_SVH
`define ALARM_TIMER_CONTROLLER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ATC_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
	else $error("assertion failed");

// next-cycle implication
`define ATC_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
	else $error("assertion failed");

`else

`define ATC_ASSERT_IMP(lbl, ck, rstn, ante, cons)
`define ATC_ASSERT_NXT(lbl, ck, rstn, ante, cons)

`endif

`endif

FILE: sv/atc_pkg.sv
// ----------------------------------------------------------------------------
// atc_pkg
// types, codes and constants of the alarm timer controller
// ----------------------------------------------------------------------------
package atc_pkg;

	localparam int CfgIndexW = 3;
	localparam int CfgDataW  = 6;
	localparam int TimerW    = 19;
	localparam int KeyW      = 27;
	localparam int ElapsedW  = 23;

	localparam logic [TimerW-1:0] TimerMax        = 19'd359999;
	localparam logic [31:0]       ServicePeriodMs = 32'd100;
	localparam logic [31:0]       FeedbackMs      = 32'd1400;
	localparam logic [31:0]       ActuatorOnMs    = 32'd220;
	localparam logic [31:0]       SnoozeSec       = 32'd300;
	localparam logic [31:0]       KeepSleep       = 32'hffff_ffff;
	localparam logic [7:0]        RingLevel       = 8'd160;

	// x / 60 = (x * MinMagic) >> MinShift, exact for 32-bit x
	localparam logic [63:0] MinMagic = 64'h0000_0000_8888_8889;
	localparam int          MinShift = 37;
	// x / 1000 = (x * MsMagic) >> MsShift, exact for 32-bit x
	localparam logic [63:0] MsMagic  = 64'd274877907;
	localparam int          MsShift  = 38;

	typedef enum logic [2:0] {
		MODE_TICK       = 3'd0,
		MODE_SLEEP_SET  = 3'd1,
		MODE_SLEEP_STOP = 3'd2,
		MODE_DISMISS    = 3'd3,
		MODE_SNOOZE     = 3'd4,
		MODE_HAPTIC     = 3'd5,
		MODE_TIMER_LOAD = 3'd6
	} mode_t;

	typedef enum logic [2:0] {
		CAUSE_NONE      = 3'd0,
		CAUSE_TIMER     = 3'd1,
		CAUSE_SLEEP     = 3'd2,
		CAUSE_SNOOZE    = 3'd3,
		CAUSE_SCHEDULED = 3'd4
	} cause_t;

	typedef enum logic [1:0] {
		LINK_NONE    = 2'd0,
		LINK_DISMISS = 2'd1,
		LINK_SNOOZE  = 2'd2
	} link_t;

	typedef enum logic [CfgIndexW-1:0] {
		CFG_WEEKDAY_EN = 3'd0,
		CFG_WEEKEND_EN = 3'd1,
		CFG_HOUR       = 3'd2,
		CFG_MINUTE     = 3'd3,
		CFG_VIBRATE_EN = 3'd4,
		CFG_QUIET_EN   = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic       weekday_alarm_enable;
		logic       weekend_alarm_enable;
		logic [4:0] wake_hour;
		logic [5:0] wake_minute;
		logic       vibration_enable;
		logic       quiet_enable;
	} cfg_t;

	localparam cfg_t CfgReset = '{
		weekday_alarm_enable: 1'b0,
		weekend_alarm_enable: 1'b0,
		wake_hour:            5'd7,
		wake_minute:          6'd0,
		vibration_enable:     1'b1,
		quiet_enable:         1'b0
	};

	typedef struct packed {
		logic [2:0]      mode;
		logic [31:0]     now_ms;
		logic [31:0]     epoch_seconds;
		logic [2:0]      weekday;
		logic [4:0]      hour;
		logic [5:0]      minute;
		logic [31:0]     amount;
		logic [7:0]      strength;
		logic            run_flag;
		logic [KeyW-1:0] minute_num;
	} item_t;

	typedef struct packed {
		logic [31:0]       sleep_alarm_time;
		logic              sleep_ringing;
		logic [31:0]       snooze_end;
		logic [31:0]       actuator_off_time;
		logic [31:0]       feedback_time;
		logic [31:0]       next_service_time;
		logic [31:0]       timer_tick_time;
		logic [TimerW-1:0] timer_seconds;
		logic              timer_run;
		logic              ring_flag;
		logic [KeyW-1:0]   last_minute_num;
		logic [7:0]        drive_level;
	} state_t;

	// all-ones key is above any epoch / 60, so it never matches
	localparam state_t StateReset = '{
		sleep_alarm_time:  32'd0,
		sleep_ringing:     1'b0,
		snooze_end:        32'd0,
		actuator_off_time: 32'd0,
		feedback_time:     32'd0,
		next_service_time: 32'd0,
		timer_tick_time:   32'd0,
		timer_seconds:     19'd0,
		timer_run:         1'b0,
		ring_flag:         1'b0,
		last_minute_num:   {KeyW{1'b1}},
		drive_level:       8'd0
	};

	typedef struct packed {
		logic              ringing;
		logic [7:0]        vibration_level;
		logic              buzzer_start;
		logic              buzzer_stop;
		cause_t            start_cause;
		link_t             link_message;
		logic              stop_dismissed;
		logic [TimerW-1:0] timer_left;
		logic              timer_active;
		logic              fast_service;
	} result_t;

	// wrapped time compare: now is at or past t
	function automatic logic reached(input logic [31:0] now, input logic [31:0] t);
		logic [31:0] diff;
		diff = now - t;
		return !diff[31];
	endfunction

endpackage

FILE: sv/atc_item_if.sv
// ----------------------------------------------------------------------------
// atc_item_if
// input channel: mode, millisecond clock, rtc time and command operands
// ----------------------------------------------------------------------------
interface atc_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [31:0] now_ms;
	logic [31:0] epoch_seconds;
	logic [2:0]  weekday;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [31:0] amount;
	logic [7:0]  strength;
	logic        run_flag;

	modport source (
		output valid, mode, now_ms, epoch_seconds, weekday, hour, minute, amount,
			strength, run_flag,
		input  ready
	);
	modport sink (
		input  valid, mode, now_ms, epoch_seconds, weekday, hour, minute, amount,
			strength, run_flag,
		output ready
	);
endinterface

FILE: sv/atc_result_if.sv
// ----------------------------------------------------------------------------
// atc_result_if
// result channel: actuator commands, link messages, start cause, timer status
// ----------------------------------------------------------------------------
interface atc_result_if;
	logic        valid;
	logic        ready;
	logic        ringing;
	logic [7:0]  vibration_level;
	logic        buzzer_start;
	logic        buzzer_stop;
	logic [2:0]  start_cause;
	logic [1:0]  link_message;
	logic        stop_dismissed;
	logic [18:0] timer_left;
	logic        timer_active;
	logic        fast_service;

	modport source (
		output valid, ringing, vibration_level, buzzer_start, buzzer_stop, start_cause,
			link_message, stop_dismissed, timer_left, timer_active, fast_service,
		input  ready
	);
	modport sink (
		input  valid, ringing, vibration_level, buzzer_start, buzzer_stop, start_cause,
			link_message, stop_dismissed, timer_left, timer_active, fast_service,
		output ready
	);
endinterface

FILE: sv/atc_cfg_regs.sv
// ----------------------------------------------------------------------------
// atc_cfg_regs
// configuration registers with a plain indexed write port
// ----------------------------------------------------------------------------
module atc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [atc_pkg::CfgIndexW-1:0] index,
	input  logic [atc_pkg::CfgDataW-1:0]  data,
	output atc_pkg::cfg_t                 cfg
);

	atc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= atc_pkg::CfgReset;
		end else if (we) begin
			case (atc_pkg::cfg_index_t'(index))
				atc_pkg::CFG_WEEKDAY_EN: begin
					cfg_q.weekday_alarm_enable <= data[0];
				end
				atc_pkg::CFG_WEEKEND_EN: begin
					cfg_q.weekend_alarm_enable <= data[0];
				end
				atc_pkg::CFG_HOUR: begin
					cfg_q.wake_hour <= data[4:0];
				end
				atc_pkg::CFG_MINUTE: begin
					cfg_q.wake_minute <= data[5:0];
				end
				atc_pkg::CFG_VIBRATE_EN: begin
					cfg_q.vibration_enable <= data[0];
				end
				atc_pkg::CFG_QUIET_EN: begin
					cfg_q.quiet_enable <= data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/atc_step.sv
// ----------------------------------------------------------------------------
// atc_step
// next state and result for one registered item
// ----------------------------------------------------------------------------
module atc_step (
	input  atc_pkg::cfg_t    cfg,
	input  atc_pkg::item_t   item,
	input  atc_pkg::state_t  st,
	output atc_pkg::state_t  st_nxt,
	output atc_pkg::result_t res
);

	logic [31:0]                   now;
	logic [31:0]                   tick_gap;
	logic [63:0]                   gap_prod;
	logic [atc_pkg::ElapsedW-1:0]  elapsed;
	logic [31:0]                   elapsed_ms;
	logic                          day_on;
	logic                          daily_hit;

	atc_pkg::state_t nx;
	atc_pkg::cause_t cause_first;
	atc_pkg::cause_t cause;
	atc_pkg::link_t  link;
	logic            buz_start;
	logic            buz_stop;
	logic            stop_hit;
	logic [31:0]     fb_gap;

	assign now = item.now_ms;

	// whole seconds since the last timer tick
	assign tick_gap   = now - st.timer_tick_time;
	assign gap_prod   = {32'd0, tick_gap} * atc_pkg::MsMagic;
	assign elapsed    = gap_prod[atc_pkg::MsShift +: atc_pkg::ElapsedW];
	// elapsed * 1000 as shifts, wraps harmlessly
	assign elapsed_ms = 32'({elapsed, 10'd0}) - 32'({elapsed, 4'd0}) - 32'({elapsed, 3'd0});

	assign day_on    = (item.weekday >= 3'd1 && item.weekday <= 3'd5) ?
		cfg.weekday_alarm_enable : cfg.weekend_alarm_enable;
	assign daily_hit = day_on && item.hour == cfg.wake_hour &&
		item.minute == cfg.wake_minute && item.minute_num != st.last_minute_num;

	always_comb begin
		nx          = st;
		cause_first = atc_pkg::CAUSE_NONE;
		cause       = atc_pkg::CAUSE_NONE;
		link        = atc_pkg::LINK_NONE;
		buz_start   = 1'b0;
		buz_stop    = 1'b0;
		stop_hit    = 1'b0;
		fb_gap      = 32'd0;

		case (atc_pkg::mode_t'(item.mode))
			atc_pkg::MODE_TICK: begin
				if (atc_pkg::reached(now, st.next_service_time)) begin
					nx.next_service_time = now + atc_pkg::ServicePeriodMs;
					if (st.timer_run && elapsed != '0) begin
						nx.timer_tick_time = st.timer_tick_time + elapsed_ms;
						if (elapsed >= {4'd0, st.timer_seconds}) begin
							nx.timer_seconds = '0;
							nx.timer_run     = 1'b0;
							cause_first      = atc_pkg::CAUSE_TIMER;
						end else begin
							nx.timer_seconds = st.timer_seconds - elapsed[atc_pkg::TimerW-1:0];
						end
					end
					if (st.sleep_alarm_time != '0 &&
						atc_pkg::reached(now, st.sleep_alarm_time)) begin
						nx.sleep_alarm_time = '0;
						nx.sleep_ringing    = 1'b1;
						if (cause_first == atc_pkg::CAUSE_NONE) begin
							cause_first = atc_pkg::CAUSE_SLEEP;
						end
					end
					if (st.snooze_end != '0 && item.epoch_seconds >= st.snooze_end) begin
						nx.snooze_end = '0;
						if (cause_first == atc_pkg::CAUSE_NONE) begin
							cause_first = atc_pkg::CAUSE_SNOOZE;
						end
					end
					if (daily_hit) begin
						nx.last_minute_num = item.minute_num;
						if (cause_first == atc_pkg::CAUSE_NONE) begin
							cause_first = atc_pkg::CAUSE_SCHEDULED;
						end
					end
					// only a start while not ringing counts
					if (!st.ring_flag && cause_first != atc_pkg::CAUSE_NONE) begin
						nx.ring_flag     = 1'b1;
						nx.feedback_time = '0;
						cause            = cause_first;
					end
				end
				// output service
				if (st.actuator_off_time != '0 &&
					atc_pkg::reached(now, st.actuator_off_time)) begin
					nx.drive_level       = '0;
					nx.actuator_off_time = '0;
					buz_stop             = 1'b1;
				end
				fb_gap = now - nx.feedback_time;
				if (nx.ring_flag && fb_gap >= atc_pkg::FeedbackMs) begin
					nx.feedback_time = now;
					if (cfg.vibration_enable) begin
						nx.drive_level = atc_pkg::RingLevel;
					end
					if (!cfg.quiet_enable) begin
						buz_start = 1'b1;
					end
					if (cfg.vibration_enable || !cfg.quiet_enable) begin
						nx.actuator_off_time = now + atc_pkg::ActuatorOnMs;
					end
				end
			end
			atc_pkg::MODE_SLEEP_SET: begin
				// zero delay stores now; all ones keeps the old time
				if (item.amount != atc_pkg::KeepSleep) begin
					nx.sleep_alarm_time = now + item.amount;
				end
			end
			atc_pkg::MODE_SLEEP_STOP: begin
				nx.sleep_alarm_time = '0;
				nx.sleep_ringing    = 1'b0;
				if (st.ring_flag) begin
					nx.ring_flag         = 1'b0;
					nx.drive_level       = '0;
					nx.actuator_off_time = '0;
					nx.snooze_end        = '0;
					buz_stop             = 1'b1;
					stop_hit             = 1'b1;
				end
			end
			atc_pkg::MODE_DISMISS: begin
				if (st.sleep_ringing) begin
					link             = atc_pkg::LINK_DISMISS;
					nx.sleep_ringing = 1'b0;
				end
				nx.ring_flag         = 1'b0;
				nx.drive_level       = '0;
				nx.actuator_off_time = '0;
				nx.snooze_end        = '0;
				buz_stop             = 1'b1;
			end
			atc_pkg::MODE_SNOOZE: begin
				if (st.sleep_ringing) begin
					link             = atc_pkg::LINK_SNOOZE;
					nx.sleep_ringing = 1'b0;
				end
				nx.ring_flag         = 1'b0;
				nx.drive_level       = '0;
				nx.actuator_off_time = '0;
				nx.snooze_end        = item.epoch_seconds + atc_pkg::SnoozeSec;
				buz_stop             = 1'b1;
			end
			atc_pkg::MODE_HAPTIC: begin
				if (!st.ring_flag) begin
					nx.drive_level       = item.strength;
					nx.actuator_off_time = now + item.amount;
				end
			end
			atc_pkg::MODE_TIMER_LOAD: begin
				nx.timer_seconds   = (item.amount > {13'd0, atc_pkg::TimerMax}) ?
					atc_pkg::TimerMax : item.amount[atc_pkg::TimerW-1:0];
				nx.timer_run       = item.run_flag;
				nx.timer_tick_time = now;
			end
			default: begin
			end
		endcase
	end

	assign st_nxt = nx;

	always_comb begin
		res.ringing         = nx.ring_flag;
		res.vibration_level = nx.drive_level;
		res.buzzer_start    = buz_start;
		res.buzzer_stop     = buz_stop;
		res.start_cause     = cause;
		res.link_message    = link;
		res.stop_dismissed  = stop_hit;
		res.timer_left      = nx.timer_seconds;
		res.timer_active    = nx.timer_run;
		res.fast_service    = nx.ring_flag || nx.actuator_off_time != '0;
	end

endmodule

FILE: sv/alarm_timer_controller_core.sv
// ----------------------------------------------------------------------------
// alarm_timer_controller_core
// alarm and timer controller: clock service, ringing feedback, user commands
// ----------------------------------------------------------------------------
// channel  | dir | handshake          | content
// item     | in  | valid/ready        | mode, ms clock, rtc time, operands
// result   | out | valid/ready        | actuator commands, link, cause, timer
// cfg      | in  | cfg_we, no ready   | cfg_index selects, cfg_data written
//
// one item per cycle unless the result stalls; the input register holds an
// item, the result register its result. the rate is set by the state loop:
// timer divide by 1000 (reciprocal multiply), state update in the same cycle
// reset puts every state and config register at its reset value at once
// with the result stalled, one more item is taken into the input register
// ----------------------------------------------------------------------------
`include "alarm_timer_controller_core_defines.svh"

module alarm_timer_controller_core (
	input  logic                          clk,
	input  logic                          arst_n,
	atc_item_if.sink                      item,
	atc_result_if.source                  result,
	input  logic                          cfg_we,
	input  logic [atc_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [atc_pkg::CfgDataW-1:0]  cfg_data
);

	atc_pkg::cfg_t    cfg;
	atc_pkg::item_t   item_s1;
	logic             valid_s1;
	atc_pkg::state_t  st_q;
	atc_pkg::state_t  st_nxt;
	atc_pkg::result_t step_res;
	atc_pkg::result_t res_q;
	logic             res_valid_q;
	logic             adv;
	logic             take;
	logic [63:0]      key_prod;

	atc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// minute number of the rtc time, only depends on the item
	assign key_prod = {32'd0, item.epoch_seconds} * atc_pkg::MinMagic;

	assign adv        = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || adv;
	assign take       = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.mode          <= item.mode;
			item_s1.now_ms        <= item.now_ms;
			item_s1.epoch_seconds <= item.epoch_seconds;
			item_s1.weekday       <= item.weekday;
			item_s1.hour          <= item.hour;
			item_s1.minute        <= item.minute;
			item_s1.amount        <= item.amount;
			item_s1.strength      <= item.strength;
			item_s1.run_flag      <= item.run_flag;
			item_s1.minute_num    <= key_prod[atc_pkg::MinShift +: atc_pkg::KeyW];
		end
	end

	atc_step u_step (
		.cfg    (cfg),
		.item   (item_s1),
		.st     (st_q),
		.st_nxt (st_nxt),
		.res    (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= atc_pkg::StateReset;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= step_res;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.ringing         = res_q.ringing;
	assign result.vibration_level = res_q.vibration_level;
	assign result.buzzer_start    = res_q.buzzer_start;
	assign result.buzzer_stop     = res_q.buzzer_stop;
	assign result.start_cause     = res_q.start_cause;
	assign result.link_message    = res_q.link_message;
	assign result.stop_dismissed  = res_q.stop_dismissed;
	assign result.timer_left      = res_q.timer_left;
	assign result.timer_active    = res_q.timer_active;
	assign result.fast_service    = res_q.fast_service;

	// an item moved on always shows up as a result
	`ATC_ASSERT_NXT(a_adv_result, clk, arst_n, adv, res_valid_q)
	// an empty input register never holds the source off
	`ATC_ASSERT_IMP(a_empty_ready, clk, arst_n, !valid_s1, item.ready)
	// a reported start cause leaves the block ringing
	`ATC_ASSERT_NXT(a_cause_rings, clk, arst_n,
		adv && step_res.start_cause != atc_pkg::CAUSE_NONE, st_q.ring_flag)
	// ringing only begins from a tick
	`ATC_ASSERT_IMP(a_ring_on_tick, clk, arst_n, $rose(st_q.ring_flag),
		$past(adv) && $past(item_s1.mode) == atc_pkg::MODE_TICK)

endmodule
